// ===== hdl/bfrc_pkg.sv =====
package bfrc_pkg;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int ADDR_W     = 48;
    localparam int OFS_W      = 32;
    localparam int PAGE_W     = 17;
    localparam int GUARD_W    = PAGE_W + 1;

    localparam logic [PAGE_W-1:0] PAGE_RESET = PAGE_W'(4096);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] usable;
        logic [ADDR_W-1:0] size;
        logic [OFS_W-1:0]  offset;
    } t_region;

    // record that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic              active;
        logic              op;
        logic [ADDR_W-1:0] need;
        logic [GUARD_W-1:0] guard;
        logic [IDX_W-1:0]  pos;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] best_use;
        logic              empty_found;
        logic [IDX_W-1:0]  empty_idx;
        logic              pos_valid;
        t_region           payload;
    } t_sweep;

    // broadcast update of one cell
    typedef struct packed {
        logic             wr;
        logic             inv;
        logic [IDX_W-1:0] idx;
        t_region          data;
    } t_cmd;

endpackage

// ===== hdl/bfrc_if.sv =====
interface bfrc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [bfrc_pkg::ADDR_W-1:0] region_base;
    logic [bfrc_pkg::ADDR_W-1:0] usable_addr;
    logic [bfrc_pkg::ADDR_W-1:0] region_size;
    logic [bfrc_pkg::OFS_W-1:0]  region_offset;
    logic [bfrc_pkg::ADDR_W-1:0] request_bytes;

    modport source (output valid, op, region_base, usable_addr, region_size,
                    region_offset, request_bytes, input ready);
    modport sink   (input valid, op, region_base, usable_addr, region_size,
                    region_offset, request_bytes, output ready);
endinterface

interface bfrc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        region_valid;
    logic [bfrc_pkg::ADDR_W-1:0] out_base;
    logic [bfrc_pkg::ADDR_W-1:0] out_usable;
    logic [bfrc_pkg::ADDR_W-1:0] out_size;
    logic [bfrc_pkg::OFS_W-1:0]  out_offset;

    modport source (output valid, region_valid, out_base, out_usable, out_size,
                    out_offset, input ready);
    modport sink   (input valid, region_valid, out_base, out_usable, out_size,
                    out_offset, output ready);
endinterface

interface bfrc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bfrc_pkg::PAGE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/bfrc_cell.sv =====
module bfrc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bfrc_pkg::IDX_W-1:0] i_idx,
    input  bfrc_pkg::t_sweep           i_sweep,
    input  bfrc_pkg::t_cmd             i_cmd,
    output bfrc_pkg::t_sweep           o_sweep
);

    logic                        r_valid;
    bfrc_pkg::t_region           r_ent;
    logic                        r_act;
    bfrc_pkg::t_sweep            r_sweep;
    bfrc_pkg::t_sweep            n_sweep;
    logic [bfrc_pkg::ADDR_W-1:0] w_cut;
    logic [bfrc_pkg::ADDR_W-1:0] w_use;
    logic                        w_fits;
    logic                        w_better;
    logic                        w_sel;

    assign w_sel = (i_cmd.idx == i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr && w_sel) begin
            r_valid <= 1'b1;
        end else if (i_cmd.inv && w_sel) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_sel) begin
            r_ent <= i_cmd.data;
        end
    end

    // usable size = size - 2 pages - offset; underflow means unusable
    assign w_cut    = bfrc_pkg::ADDR_W'(i_sweep.guard) + bfrc_pkg::ADDR_W'(r_ent.offset);
    assign w_use    = r_ent.size - w_cut;
    assign w_fits   = r_valid && (r_ent.size >= w_cut) && (w_use >= i_sweep.need);
    assign w_better = !i_sweep.hit || (w_use < i_sweep.best_use);

    always_comb begin
        n_sweep = i_sweep;
        if (i_sweep.op == bfrc_pkg::OP_LOOKUP) begin
            if (w_fits && w_better) begin
                n_sweep.hit      = 1'b1;
                n_sweep.idx      = i_idx;
                n_sweep.best_use = w_use;
                n_sweep.payload  = r_ent;
            end
        end else begin
            if (!r_valid && !i_sweep.empty_found) begin
                n_sweep.empty_found = 1'b1;
                n_sweep.empty_idx   = i_idx;
            end
            if (i_idx == i_sweep.pos) begin
                n_sweep.pos_valid = r_valid;
                n_sweep.payload   = r_ent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= i_sweep.active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sweep <= n_sweep;
    end

    always_comb begin
        o_sweep        = r_sweep;
        o_sweep.active = r_act;
    end

endmodule

// ===== hdl/best_fit_region_cache.sv =====
// Best-fit cache of free memory regions.
// i_in  : request items. op insert stores a freed region at the round-robin
//         slot (or the lowest empty slot when that one is taken); op lookup
//         removes the region with the smallest usable size covering request_bytes.
// o_out : exactly one item per request. region_valid marks an evicted
//         region (insert into a full table) or a found one (lookup); all
//         fields read zero otherwise.
// i_cfg : page size write, always ready; write only while idle.
// Path: the accept edge loads the first of 16 cells and the request
//   record moves one cell per cycle, one entry per cell; the finished
//   record is then latched, and once the output register is free the
//   chosen cell is updated and the output register loaded together.
// Flow: one item at a time; a new item is accepted only after the
//   previous one has updated the table, and it may be accepted while the
//   previous result still waits in the output register.
// Stall: if o_out is not taken, the finished sweep waits and the table is
//   not updated until the output register frees.
// Reset: all entries invalid, round-robin pointer 0, page size 4096.
module best_fit_region_cache (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bfrc_in_if.sink           i_in,
    bfrc_out_if.source        o_out,
    bfrc_cfg_if.sink          i_cfg
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_COMMIT = 3'b100
    } t_state;

    t_state                        r_state;
    logic [bfrc_pkg::PAGE_W-1:0]   r_page;
    logic [bfrc_pkg::IDX_W-1:0]    r_ring;
    bfrc_pkg::t_region             r_ins;
    bfrc_pkg::t_sweep              r_fin;
    logic                          r_out_valid;
    logic                          r_out_hit;
    bfrc_pkg::t_region             r_out;

    logic                          w_accept;
    logic                          w_go;
    logic                          w_evict;
    logic                          w_ret;
    bfrc_pkg::t_sweep              w_launch;
    bfrc_pkg::t_cmd                w_cmd;
    bfrc_pkg::t_sweep              w_chain [bfrc_pkg::DEPTH+1];

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= bfrc_pkg::PAGE_RESET;
        end else if (i_cfg.valid) begin
            r_page <= i_cfg.data;
        end
    end

    // record entering the first cell
    always_comb begin
        w_launch        = '0;
        w_launch.active = w_accept;
        w_launch.op     = i_in.op;
        w_launch.need   = i_in.request_bytes;
        w_launch.guard  = {r_page, 1'b0};
        w_launch.pos    = r_ring;
    end

    assign w_chain[0] = w_launch;

    for (genvar g = 0; g < bfrc_pkg::DEPTH; g++) begin : g_cell
        bfrc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (bfrc_pkg::IDX_W'(g)),
            .i_sweep (w_chain[g]),
            .i_cmd   (w_cmd),
            .o_sweep (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ins.base   <= i_in.region_base;
            r_ins.usable <= i_in.usable_addr;
            r_ins.size   <= i_in.region_size;
            r_ins.offset <= i_in.region_offset;
        end
        if (w_chain[bfrc_pkg::DEPTH].active) begin
            r_fin <= w_chain[bfrc_pkg::DEPTH];
        end
    end

    assign w_go    = (r_state == ST_COMMIT) && (!r_out_valid || o_out.ready);
    // insert into a full table pushes out the slot under the pointer
    assign w_evict = (r_fin.op == bfrc_pkg::OP_INSERT) && r_fin.pos_valid
                     && !r_fin.empty_found;
    assign w_ret   = (r_fin.op == bfrc_pkg::OP_LOOKUP) ? r_fin.hit : w_evict;

    always_comb begin
        w_cmd      = '0;
        w_cmd.data = r_ins;
        if (w_go) begin
            if (r_fin.op == bfrc_pkg::OP_LOOKUP) begin
                w_cmd.inv = r_fin.hit;
                w_cmd.idx = r_fin.idx;
            end else begin
                w_cmd.wr  = 1'b1;
                w_cmd.idx = (r_fin.pos_valid && r_fin.empty_found) ?
                            r_fin.empty_idx : r_fin.pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ring  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (w_chain[bfrc_pkg::DEPTH].active) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (w_go) begin
                        r_state <= ST_IDLE;
                        if (r_fin.op == bfrc_pkg::OP_INSERT) begin
                            r_ring <= (r_ring == bfrc_pkg::IDX_W'(bfrc_pkg::DEPTH - 1)) ?
                                      '0 : r_ring + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_hit <= w_ret;
            r_out     <= w_ret ? r_fin.payload : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.region_valid = r_out_hit;
    assign o_out.out_base     = r_out.base;
    assign o_out.out_usable   = r_out.usable;
    assign o_out.out_size     = r_out.size;
    assign o_out.out_offset   = r_out.offset;

endmodule

// ===== tb/best_fit_region_cache_checker.sv =====
module best_fit_region_cache_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bfrc_in_if   i_in,
    bfrc_out_if  i_out,
    bfrc_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              hit;
        bfrc_pkg::t_region region;
    } t_return;

    logic [bfrc_pkg::DEPTH-1:0]  slot_live;
    bfrc_pkg::t_region           slot_data [bfrc_pkg::DEPTH];
    logic [bfrc_pkg::IDX_W-1:0]  ring_ptr;
    logic [bfrc_pkg::PAGE_W-1:0] page_size;
    t_return                     due_returns [$];

    // Applies one request to the shadow table, gives the region it returns.
    function automatic t_return cache_access(input logic op,
                                             input bfrc_pkg::t_region req,
                                             input logic [bfrc_pkg::ADDR_W-1:0] need);
        t_return                     ret;
        logic [bfrc_pkg::IDX_W-1:0]  tgt;
        logic                        placed;
        logic [63:0]                 guard;
        logic [63:0]                 cut;
        logic [bfrc_pkg::ADDR_W-1:0] avail;
        logic [bfrc_pkg::ADDR_W-1:0] best_avail;
        int                          i;
        ret = '0;
        if (op == bfrc_pkg::OP_INSERT) begin
            tgt = ring_ptr;
            if (slot_live[ring_ptr]) begin
                placed = 1'b0;
                for (i = 0; i < bfrc_pkg::DEPTH; i++) begin
                    if (!placed && !slot_live[i]) begin
                        tgt = bfrc_pkg::IDX_W'(i);
                        placed = 1'b1;
                    end
                end
                if (!placed) begin
                    ret.hit = 1'b1;
                    ret.region = slot_data[ring_ptr];
                end
            end
            slot_live[tgt] = 1'b1;
            slot_data[tgt] = req;
            ring_ptr = bfrc_pkg::IDX_W'((int'(ring_ptr) + 1) % bfrc_pkg::DEPTH);
        end else begin
            guard = 64'(page_size) * 2;
            best_avail = '0;
            tgt = '0;
            for (i = 0; i < bfrc_pkg::DEPTH; i++) begin
                cut = guard + 64'(slot_data[i].offset);
                if (slot_live[i] && 64'(slot_data[i].size) >= cut) begin
                    avail = bfrc_pkg::ADDR_W'(64'(slot_data[i].size) - cut);
                    if (avail >= need && (!ret.hit || avail < best_avail)) begin
                        ret.hit = 1'b1;
                        tgt = bfrc_pkg::IDX_W'(i);
                        best_avail = avail;
                    end
                end
            end
            if (ret.hit) begin
                ret.region = slot_data[tgt];
                slot_live[tgt] = 1'b0;
            end
        end
        return ret;
    endfunction

    task automatic check_field(input string name,
                               input logic [bfrc_pkg::ADDR_W-1:0] want,
                               input logic [bfrc_pkg::ADDR_W-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_return           want;
        bfrc_pkg::t_region req;
        if (!i_rst_n) begin
            slot_live    = '0;
            ring_ptr     = '0;
            page_size    = bfrc_pkg::PAGE_RESET;
            o_fail_count = 0;
            due_returns.delete();
            for (int i = 0; i < bfrc_pkg::DEPTH; i++) slot_data[i] = '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) page_size = i_cfg.data;
            if (i_out.valid && i_out.ready) begin
                if (due_returns.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result item, expected none, actual valid=%0b base=%h",
                             $time, i_out.region_valid, i_out.out_base);
                end else begin
                    want = due_returns.pop_front();
                    check_field("region_valid", bfrc_pkg::ADDR_W'(want.hit),
                                bfrc_pkg::ADDR_W'(i_out.region_valid));
                    check_field("out_base", want.region.base, i_out.out_base);
                    check_field("out_usable", want.region.usable, i_out.out_usable);
                    check_field("out_size", want.region.size, i_out.out_size);
                    check_field("out_offset", bfrc_pkg::ADDR_W'(want.region.offset),
                                bfrc_pkg::ADDR_W'(i_out.out_offset));
                end
            end
            if (i_in.valid && i_in.ready) begin
                req.base   = i_in.region_base;
                req.usable = i_in.usable_addr;
                req.size   = i_in.region_size;
                req.offset = i_in.region_offset;
                due_returns.push_back(cache_access(i_in.op, req, i_in.request_bytes));
            end
        end
        o_pending = due_returns.size();
    end

endmodule

// ===== tb/best_fit_region_cache_tb.sv =====
module best_fit_region_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;

    bfrc_in_if  req_ch ();
    bfrc_out_if rsp_ch ();
    bfrc_cfg_if cfg_ch ();

    int                          fail_count;
    int                          pending;
    int                          send_idle_pct = 15;
    int                          recv_idle_pct = 50;
    // page size last written, so stimulus can aim sizes around the guard
    logic [bfrc_pkg::PAGE_W-1:0] cur_page = bfrc_pkg::PAGE_RESET;

    best_fit_region_cache uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    best_fit_region_cache_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (req_ch),
        .i_out        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop: well above the slowest legal run (~1500 items, stalls included).
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: ready toggles at falling edges with the current stall rate.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [bfrc_pkg::ADDR_W-1:0] rand48();
        return bfrc_pkg::ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic bfrc_pkg::t_region make_region(
        input logic [bfrc_pkg::ADDR_W-1:0] base,
        input logic [bfrc_pkg::ADDR_W-1:0] usable,
        input logic [bfrc_pkg::ADDR_W-1:0] size,
        input logic [bfrc_pkg::OFS_W-1:0]  offset);
        bfrc_pkg::t_region r;
        r.base   = base;
        r.usable = usable;
        r.size   = size;
        r.offset = offset;
        return r;
    endfunction

    // Region with a size chosen relative to the two-page guard: mostly a
    // usable size on a coarse grid (so ties show up), sometimes underflowing,
    // sometimes wide open.
    function automatic bfrc_pkg::t_region random_region();
        bfrc_pkg::t_region r;
        logic [63:0]       guard;
        logic [63:0]       cut;
        logic [63:0]       avail;
        guard    = 64'(cur_page) * 2;
        r.base   = rand48();
        r.usable = rand48();
        avail    = 64'($urandom_range(15) * 256 + ($urandom_range(1) ? 0 : $urandom_range(255)));
        case ($urandom_range(9))
            0: begin
                r.size   = rand48();
                r.offset = $urandom();
            end
            1: begin
                r.size   = '1;
                r.offset = $urandom();
            end
            2: begin
                // size just short of guard plus offset: never usable, unless both are zero
                r.offset = $urandom_range(255);
                cut      = guard + 64'(r.offset);
                if (cut == 0) r.size = '0;
                else r.size = bfrc_pkg::ADDR_W'(cut -
                        64'($urandom_range(1, int'(cut > 4096 ? 4096 : cut))));
            end
            3: begin
                r.offset = $urandom();
                r.size   = bfrc_pkg::ADDR_W'(guard + 64'(r.offset) + avail);
            end
            default: begin
                r.offset = $urandom_range(255);
                r.size   = bfrc_pkg::ADDR_W'(guard + 64'(r.offset) + avail);
            end
        endcase
        return r;
    endfunction

    // One request item; sender gaps come before it. Called at a falling edge,
    // returns at the falling edge after acceptance with valid still high.
    task automatic send_request(input logic op, input bfrc_pkg::t_region r,
                                input logic [bfrc_pkg::ADDR_W-1:0] need);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.op            = op;
        req_ch.region_base   = r.base;
        req_ch.usable_addr   = r.usable;
        req_ch.region_size   = r.size;
        req_ch.region_offset = r.offset;
        req_ch.request_bytes = need;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Page size update, only once the block has drained.
    task automatic write_page(input logic [bfrc_pkg::PAGE_W-1:0] value);
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        cur_page     = value;
    endtask

    initial begin
        logic [bfrc_pkg::PAGE_W-1:0] page_plan [6];
        logic [63:0]                 guard;
        logic                        op;
        logic [bfrc_pkg::ADDR_W-1:0] need;
        int                          ins_pct;

        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.op            = bfrc_pkg::OP_INSERT;
        req_ch.region_base   = '0;
        req_ch.usable_addr   = '0;
        req_ch.region_size   = '0;
        req_ch.region_offset = '0;
        req_ch.request_bytes = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, page size at its reset value.
        guard = 64'(cur_page) * 2;
        // lookup on an empty table: no fit
        send_request(bfrc_pkg::OP_LOOKUP, random_region(), '0);
        // slot 0: all zero, size underflows the guard
        send_request(bfrc_pkg::OP_INSERT, make_region('0, '0, '0, '0), rand48());
        // slot 1: every field at its maximum
        send_request(bfrc_pkg::OP_INSERT, make_region('1, '1, '1, '1), rand48());
        // slot 2: usable 1000 behind an offset of 100
        send_request(bfrc_pkg::OP_INSERT, make_region(rand48(), rand48(),
                     bfrc_pkg::ADDR_W'(guard + 1100), 32'd100), rand48());
        // slot 3: size exactly guard plus offset, usable size zero
        send_request(bfrc_pkg::OP_INSERT, make_region(rand48(), rand48(),
                     bfrc_pkg::ADDR_W'(guard + 7), 32'd7), rand48());
        // slot 4: one byte short of guard plus offset
        send_request(bfrc_pkg::OP_INSERT, make_region(rand48(), rand48(),
                     bfrc_pkg::ADDR_W'(guard + 49), 32'd50), rand48());
        // slot 5: usable 1000 again, a tie with slot 2
        send_request(bfrc_pkg::OP_INSERT, make_region(rand48(), rand48(),
                     bfrc_pkg::ADDR_W'(guard + 1000), '0), rand48());
        // tie goes to the lower slot, then the other one
        send_request(bfrc_pkg::OP_LOOKUP, random_region(), bfrc_pkg::ADDR_W'(1000));
        send_request(bfrc_pkg::OP_LOOKUP, random_region(), bfrc_pkg::ADDR_W'(1000));
        // zero request takes the zero-usable entry, not the underflowing ones
        send_request(bfrc_pkg::OP_LOOKUP, random_region(), '0);
        // largest request: nothing fits, table unchanged
        send_request(bfrc_pkg::OP_LOOKUP, random_region(), '1);
        send_request(bfrc_pkg::OP_LOOKUP, random_region(), bfrc_pkg::ADDR_W'(1));
        // fill up past full: placement at the pointer, then lowest-empty placement, then evictions at the pointer
        repeat (16) send_request(bfrc_pkg::OP_INSERT, random_region(), rand48());

        // Random part: six page settings, extremes and out-of-range ones included.
        page_plan[0] = bfrc_pkg::PAGE_W'(1);
        page_plan[1] = bfrc_pkg::PAGE_W'(65536);
        page_plan[2] = '0;
        page_plan[3] = '1;
        page_plan[4] = bfrc_pkg::PAGE_RESET;
        page_plan[5] = bfrc_pkg::PAGE_W'($urandom_range(2, 65535));
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 50 : 0;
            recv_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 15 : 0;
            write_page(page_plan[ph]);
            for (int n = 0; n < 250; n++) begin
                // insert-heavy stretches fill the table and force evictions,
                // lookup-heavy ones drain it
                ins_pct = ((n / 40) % 2) ? 35 : 75;
                op = ($urandom_range(99) < ins_pct) ? bfrc_pkg::OP_INSERT
                                                    : bfrc_pkg::OP_LOOKUP;
                case ($urandom_range(9))
                    0:       need = rand48();
                    1:       need = '0;
                    2:       need = '1;
                    default: need = bfrc_pkg::ADDR_W'($urandom_range(4096));
                endcase
                send_request(op, random_region(), need);
            end
        end
        req_ch.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bfrc_pkg.sv
hdl/bfrc_if.sv
hdl/bfrc_cell.sv
hdl/best_fit_region_cache.sv
tb/best_fit_region_cache_checker.sv
tb/best_fit_region_cache_tb.sv
